[hw/rtl/motor_startup_sequencer_defines.svh]
// Assertion macros used by the motor startup sequencer top level.
`ifndef MOTOR_STARTUP_SEQUENCER_DEFINES_SVH
`define MOTOR_STARTUP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define MSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define MSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mss_pkg.sv]
// Shared types, codes, constants and the transition table of the startup sequencer.
`default_nettype none

package mss_pkg;

    localparam int CALIB_SAMPLES = 500;
    localparam int CALIB_CNT_W   = $clog2(CALIB_SAMPLES + 1);
    localparam int SUM_W         = 21;
    localparam int ADC_W         = 12;
    localparam int VBUS_W        = 16;
    localparam int ENC_W         = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int NUM_ADC       = 3;

    // Reciprocal of the sample count, exact for every sum below 2**SUM_W.
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 32;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] CALIB_RECIP = RECIP_W'(
        ((64'd1 << RECIP_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

    localparam logic [CFG_W-1:0] BUS_LOW_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] BUS_HIGH_RST    = 16'd60000;
    localparam logic [CFG_W-1:0] ALIGN_TICKS_RST = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUS_LOW     = 2'd0,
        CFG_BUS_HIGH    = 2'd1,
        CFG_ALIGN_TICKS = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_RESET = 3'd0,
        ST_INIT  = 3'd1,
        ST_READY = 3'd2,
        ST_CALIB = 3'd3,
        ST_ALIGN = 3'd4,
        ST_RUN   = 3'd5,
        ST_FAULT = 3'd6
    } state_t;

    typedef enum logic [3:0] {
        EV_FAULT      = 4'd0,
        EV_CLEAR      = 4'd1,
        EV_RESET      = 4'd2,
        EV_START      = 4'd3,
        EV_BUS_WAIT   = 4'd4,
        EV_BUS_OK     = 4'd5,
        EV_RESTART    = 4'd6,
        EV_HOLD       = 4'd7,
        EV_READY      = 4'd8,
        EV_CALIB      = 4'd9,
        EV_CALIB_DONE = 4'd10,
        EV_ALIGN      = 4'd11,
        EV_ALIGN_DONE = 4'd12,
        EV_RUN        = 4'd13,
        EV_FLASH_ON   = 4'd14
    } evt_t;

    typedef enum logic [2:0] {
        HND_FAULT = 3'd0,
        HND_RESET = 3'd1,
        HND_INIT  = 3'd2,
        HND_READY = 3'd3,
        HND_CALIB = 3'd4,
        HND_ALIGN = 3'd5,
        HND_RUN   = 3'd6
    } hnd_t;

    typedef enum logic [1:0] {
        PH_D_AXIS = 2'd0,
        PH_Q_AXIS = 2'd1,
        PH_Q_DONE = 2'd2
    } align_ph_t;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_D    = 2'd1,
        AXIS_Q    = 2'd2
    } axis_t;

    typedef struct packed {
        logic                          done;
        logic [NUM_ADC-1:0][ADC_W-1:0] offset;
    } calib_out_t;

    // Event by state transition table; unknown event codes land in fault.
    function automatic hnd_t handler_sel(evt_t ev, state_t st);
        hnd_t h;
        h = HND_FAULT;
        unique case (ev)
            EV_FAULT:      h = HND_FAULT;
            EV_CLEAR:      if (st == ST_FAULT) h = HND_INIT;
            EV_RESET:      if (st == ST_RESET || st == ST_INIT || st == ST_READY) h = HND_RESET;
            EV_START:      if (st == ST_RESET) h = HND_INIT;
            EV_BUS_WAIT:   if (st == ST_INIT) h = HND_INIT;
            EV_BUS_OK:     if (st == ST_INIT) h = HND_READY;
            EV_RESTART:
            begin
                if (st == ST_READY)
                    h = HND_READY;
                else if (st == ST_CALIB || st == ST_ALIGN || st == ST_RUN)
                    h = HND_INIT;
            end
            EV_HOLD:       if (st == ST_READY) h = HND_READY;
            EV_READY:      if (st == ST_READY) h = HND_CALIB;
            EV_CALIB:      if (st == ST_CALIB) h = HND_CALIB;
            EV_CALIB_DONE: if (st == ST_CALIB) h = HND_ALIGN;
            EV_ALIGN:      if (st == ST_ALIGN) h = HND_ALIGN;
            EV_ALIGN_DONE: if (st == ST_ALIGN) h = HND_RUN;
            EV_RUN:        if (st == ST_RUN) h = HND_RUN;
            EV_FLASH_ON:   if (st == ST_READY) h = HND_RUN;
            default:       h = HND_FAULT;
        endcase
        return h;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/mss_calib.sv]
// ADC zero-offset calibration: per-channel accumulators and reciprocal averaging.
`default_nettype none

module mss_calib
    import mss_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [NUM_ADC-1:0][ADC_W-1:0] adc,
    output calib_out_t                         stat
);

    logic [CALIB_CNT_W-1:0]        count_reg;
    logic [NUM_ADC-1:0][SUM_W-1:0] sum_reg;
    logic [NUM_ADC-1:0][ADC_W-1:0] held_reg;
    logic [NUM_ADC-1:0][ADC_W-1:0] avg;
    logic [PROD_W-1:0]             prod [NUM_ADC];
    logic                          done;

    assign done = (count_reg >= CALIB_CNT_W'(CALIB_SAMPLES));

    // Divide each sum by the sample count through the reciprocal
    always_comb
    begin
        for (int i = 0; i < NUM_ADC; i++)
        begin
            prod[i] = PROD_W'(sum_reg[i]) * PROD_W'(CALIB_RECIP);
            avg[i]  = prod[i][RECIP_SHIFT +: ADC_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            held_reg  <= '0;
        end
        else if (step)
        begin
            if (!done)
            begin
                for (int i = 0; i < NUM_ADC; i++)
                    sum_reg[i] <= sum_reg[i] + SUM_W'(adc[i]);
                count_reg <= count_reg + 1'b1;
            end
            else
            begin
                held_reg  <= avg;
                sum_reg   <= '0;
                count_reg <= '0;
            end
        end
    end

    assign stat.done   = done;
    assign stat.offset = (step && done) ? avg : held_reg;

endmodule

`default_nettype wire

[hw/rtl/motor_startup_sequencer.sv]
// Top level of the motor startup sequencer: tick pipeline, state machine and alignment.
// Each accepted request waits in the input stage until the result register is empty
//   or being drained. Throughput: one request per clock while results are taken; the
//   table step and the reciprocal multiply of the calibration averages are combinational.
// Reset: rst_n is asynchronous, active low; it empties both pipeline stages, puts the
//   machine in the reset state with the reset event pending and loads register defaults.
`default_nettype none

`include "motor_startup_sequencer_defines.svh"

module motor_startup_sequencer
    import mss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // Configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,

    // Tick request channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 ext_event_valid,
    input  wire logic [3:0]           ext_event,
    input  wire logic [VBUS_W-1:0]    bus_voltage,
    input  wire logic [ADC_W-1:0]     adc_a,
    input  wire logic [ADC_W-1:0]     adc_b,
    input  wire logic [ADC_W-1:0]     adc_c,
    input  wire logic [ENC_W-1:0]     encoder_position,

    // Result channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                state_code,
    output logic [3:0]                next_event,
    output logic                      pwm_disable,
    output logic [1:0]                align_axis,
    output logic                      run_active,
    output logic                      driver_init,
    output logic                      offset_valid,
    output logic [ADC_W-1:0]          offset_a,
    output logic [ADC_W-1:0]          offset_b,
    output logic [ADC_W-1:0]          offset_c,
    output logic [ENC_W-1:0]          rotor_offset,
    output logic                      observer_init
);

    // Configuration registers
    logic [CFG_W-1:0] bus_low_reg;
    logic [CFG_W-1:0] bus_high_reg;
    logic [CFG_W-1:0] align_ticks_reg;

    // Input stage
    logic                          s1_valid_reg;
    logic                          s1_ev_valid_reg;
    logic [3:0]                    s1_ev_reg;
    logic [VBUS_W-1:0]             s1_vbus_reg;
    logic [NUM_ADC-1:0][ADC_W-1:0] s1_adc_reg;
    logic [ENC_W-1:0]              s1_enc_reg;
    logic                          s1_advance;
    logic                          in_accept;

    // Sequencer state
    state_t           state_reg,       state_next;
    evt_t             pend_reg,        pend_next;
    logic [CFG_W-1:0] align_count_reg, align_count_next;
    align_ph_t        align_phase_reg, align_phase_next;
    logic [ENC_W-1:0] enc_offset_reg,  enc_offset_next;

    // Per-tick decode
    evt_t       tick_ev;
    hnd_t       hnd;
    logic       bus_ok;
    logic       align_busy;
    logic       calib_step;
    calib_out_t calib_stat;

    // Per-tick outputs
    logic  pwm_off;
    axis_t axis;
    logic  run;
    logic  drv;
    logic  ovalid;
    logic  obs;

    // Result register
    logic                          out_valid_reg;
    state_t                        out_state_reg;
    evt_t                          out_next_ev_reg;
    logic                          out_pwm_off_reg;
    axis_t                         out_axis_reg;
    logic                          out_run_reg;
    logic                          out_drv_reg;
    logic                          out_ovalid_reg;
    logic [NUM_ADC-1:0][ADC_W-1:0] out_offset_reg;
    logic [ENC_W-1:0]              out_enc_reg;
    logic                          out_obs_reg;

    //--------------------------------------------------------------------------
    // Configuration: take a write whenever the enable is high; drop unknown indexes
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_low_reg     <= BUS_LOW_RST;
            bus_high_reg    <= BUS_HIGH_RST;
            align_ticks_reg <= ALIGN_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BUS_LOW:     bus_low_reg     <= cfg_wdata;
                CFG_BUS_HIGH:    bus_high_reg    <= cfg_wdata;
                CFG_ALIGN_TICKS: align_ticks_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // Pipeline control: the input stage advances whenever the result register
    // is empty or being drained, so a new request can enter every cycle.
    //--------------------------------------------------------------------------
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    // Hold the request payload in the input stage
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ev_valid_reg <= ext_event_valid;
            s1_ev_reg       <= ext_event;
            s1_vbus_reg     <= bus_voltage;
            s1_adc_reg      <= {adc_c, adc_b, adc_a};
            s1_enc_reg      <= encoder_position;
        end
    end

    //--------------------------------------------------------------------------
    // Tick decode: an external event overrides the pending one, then the
    // transition table picks the handler for this tick.
    //--------------------------------------------------------------------------
    assign tick_ev    = s1_ev_valid_reg ? evt_t'(s1_ev_reg) : pend_reg;
    assign hnd        = handler_sel(tick_ev, state_reg);
    assign bus_ok     = (s1_vbus_reg > bus_low_reg) && (s1_vbus_reg < bus_high_reg);
    assign align_busy = (align_count_reg < align_ticks_reg);
    assign calib_step = s1_advance && (hnd == HND_CALIB);

    mss_calib u_calib
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (calib_step),
        .adc   (s1_adc_reg),
        .stat  (calib_stat)
    );

    //--------------------------------------------------------------------------
    // Next state: state, pending event and alignment progress
    //--------------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        pend_next        = pend_reg;
        align_count_next = align_count_reg;
        align_phase_next = align_phase_reg;
        enc_offset_next  = enc_offset_reg;

        unique case (hnd)
            HND_RESET:
            begin
                state_next = ST_RESET;
                pend_next  = EV_START;
            end
            HND_INIT:
            begin
                state_next = ST_INIT;
                pend_next  = bus_ok ? EV_BUS_OK : EV_BUS_WAIT;
            end
            HND_READY:
            begin
                state_next = ST_READY;
                pend_next  = EV_READY;
            end
            HND_CALIB:
            begin
                state_next = ST_CALIB;
                pend_next  = calib_stat.done ? EV_CALIB_DONE : EV_CALIB;
            end
            HND_ALIGN:
            begin
                state_next = ST_ALIGN;
                pend_next  = EV_ALIGN;
                // Drive the current axis until the tick budget runs out, then
                // step d capture -> q drive -> q settle -> done.
                priority if (align_busy)
                begin
                    align_count_next = align_count_reg + 1'b1;
                end
                else if (align_phase_reg == PH_Q_AXIS)
                begin
                    align_phase_next = PH_Q_DONE;
                end
                else if (align_phase_reg == PH_Q_DONE)
                begin
                    align_count_next = '0;
                    align_phase_next = PH_D_AXIS;
                    pend_next        = EV_ALIGN_DONE;
                end
                else
                begin
                    align_count_next = '0;
                    align_phase_next = PH_Q_AXIS;
                    enc_offset_next  = s1_enc_reg;
                end
            end
            HND_RUN:
            begin
                state_next = ST_RUN;
                pend_next  = EV_RUN;
            end
            default:
            begin
                state_next = ST_FAULT;
                pend_next  = EV_FAULT;
            end
        endcase
    end

    //--------------------------------------------------------------------------
    // Outputs of this tick
    //--------------------------------------------------------------------------
    always_comb
    begin
        pwm_off = 1'b0;
        axis    = AXIS_NONE;
        run     = 1'b0;
        drv     = 1'b0;
        ovalid  = 1'b0;
        obs     = 1'b0;

        unique case (hnd)
            HND_RESET: pwm_off = 1'b1;
            HND_INIT:
            begin
                pwm_off = 1'b1;
                drv     = 1'b1;
            end
            HND_READY: ;
            HND_CALIB: ovalid = calib_stat.done;
            HND_ALIGN:
            begin
                if (align_busy)
                    axis = (align_phase_reg == PH_D_AXIS) ? AXIS_D : AXIS_Q;
                else
                    obs = (align_phase_reg == PH_Q_DONE);
            end
            HND_RUN:   run = 1'b1;
            default:   pwm_off = 1'b1;
        endcase
    end

    //--------------------------------------------------------------------------
    // State registers: advance only when the tick moves into the result register
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RESET;
            pend_reg        <= EV_RESET;
            align_count_reg <= '0;
            align_phase_reg <= PH_D_AXIS;
            enc_offset_reg  <= '0;
        end
        else if (s1_advance)
        begin
            state_reg       <= state_next;
            pend_reg        <= pend_next;
            align_count_reg <= align_count_next;
            align_phase_reg <= align_phase_next;
            enc_offset_reg  <= enc_offset_next;
        end
    end

    //--------------------------------------------------------------------------
    // Result register
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_state_reg   <= state_next;
            out_next_ev_reg <= pend_next;
            out_pwm_off_reg <= pwm_off;
            out_axis_reg    <= axis;
            out_run_reg     <= run;
            out_drv_reg     <= drv;
            out_ovalid_reg  <= ovalid;
            out_offset_reg  <= calib_stat.offset;
            out_enc_reg     <= enc_offset_next;
            out_obs_reg     <= obs;
        end
    end

    assign out_valid      = out_valid_reg;
    assign state_code     = out_state_reg;
    assign next_event     = out_next_ev_reg;
    assign pwm_disable    = out_pwm_off_reg;
    assign align_axis     = out_axis_reg;
    assign run_active     = out_run_reg;
    assign driver_init    = out_drv_reg;
    assign offset_valid   = out_ovalid_reg;
    assign offset_a       = out_offset_reg[0];
    assign offset_b       = out_offset_reg[1];
    assign offset_c       = out_offset_reg[2];
    assign rotor_offset   = out_enc_reg;
    assign observer_init  = out_obs_reg;

    //--------------------------------------------------------------------------
    // Checks
    //--------------------------------------------------------------------------
    `MSS_ASSERT_IMP(a_obs_in_align, clk, rst_n,
        out_valid_reg && out_obs_reg,
        out_state_reg == ST_ALIGN && out_next_ev_reg == EV_ALIGN_DONE,
        "observer init outside alignment completion")
    `MSS_ASSERT_IMP(a_ovalid_in_calib, clk, rst_n,
        out_valid_reg && out_ovalid_reg,
        out_state_reg == ST_CALIB && out_next_ev_reg == EV_CALIB_DONE,
        "offset valid outside calibration completion")
    `MSS_ASSERT_IMP(a_axis_drive, clk, rst_n,
        out_valid_reg && out_axis_reg != AXIS_NONE,
        out_state_reg == ST_ALIGN && !out_pwm_off_reg,
        "axis driven outside alignment or with PWM off")
    `MSS_ASSERT_IMP(a_ready_when_empty, clk, rst_n,
        !out_valid_reg,
        in_ready,
        "input stalled while result register is empty")
    `MSS_ASSERT_NXT(a_advance_fills, clk, rst_n,
        s1_advance,
        out_valid_reg,
        "advanced tick did not reach the result register")

endmodule

`default_nettype wire

[tb/sv/startup_seq_checker.sv]
// Checker for the startup sequencer: tracks the tick and result channels and scores each result.
`timescale 1ns / 1ps

module startup_seq_checker
    import mss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 ext_event_valid,
    input  logic [3:0]           ext_event,
    input  logic [VBUS_W-1:0]    bus_voltage,
    input  logic [ADC_W-1:0]     adc_a,
    input  logic [ADC_W-1:0]     adc_b,
    input  logic [ADC_W-1:0]     adc_c,
    input  logic [ENC_W-1:0]     encoder_position,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [2:0]           state_code,
    input  logic [3:0]           next_event,
    input  logic                 pwm_disable,
    input  logic [1:0]           align_axis,
    input  logic                 run_active,
    input  logic                 driver_init,
    input  logic                 offset_valid,
    input  logic [ADC_W-1:0]     offset_a,
    input  logic [ADC_W-1:0]     offset_b,
    input  logic [ADC_W-1:0]     offset_c,
    input  logic [ENC_W-1:0]     rotor_offset,
    input  logic                 observer_init,
    output int                   mismatch_count,
    output int                   results_owed
);

    typedef struct packed {
        state_t           state;
        logic [3:0]       nxt;
        logic             pwm_off;
        axis_t            axis;
        logic             run;
        logic             drv;
        logic             ovalid;
        logic [ADC_W-1:0] off_a;
        logic [ADC_W-1:0] off_b;
        logic [ADC_W-1:0] off_c;
        logic [ENC_W-1:0] enc_off;
        logic             obs;
    } tick_result_t;

    // sequencer copy
    state_t           seq_state;
    logic [3:0]       seq_event;
    logic [9:0]       calib_n;
    logic [SUM_W-1:0] calib_acc [NUM_ADC];
    logic [15:0]      align_n;
    align_ph_t        align_ph;
    logic [ENC_W-1:0] enc_hold;
    logic [ADC_W-1:0] offs_hold [NUM_ADC];

    // register copy
    logic [CFG_W-1:0] win_low;
    logic [CFG_W-1:0] win_high;
    logic [CFG_W-1:0] align_len;

    tick_result_t owed_q [$];

    initial mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got, input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
    endtask

    function automatic hnd_t pick_handler(logic [3:0] ev, state_t st);
        case (ev)
            EV_CLEAR:      return (st == ST_FAULT) ? HND_INIT : HND_FAULT;
            EV_RESET:      return (st == ST_RESET || st == ST_INIT || st == ST_READY)
                                  ? HND_RESET : HND_FAULT;
            EV_START:      return (st == ST_RESET) ? HND_INIT : HND_FAULT;
            EV_BUS_WAIT:   return (st == ST_INIT) ? HND_INIT : HND_FAULT;
            EV_BUS_OK:     return (st == ST_INIT) ? HND_READY : HND_FAULT;
            EV_RESTART:
            begin
                if (st == ST_READY)
                    return HND_READY;
                if (st == ST_CALIB || st == ST_ALIGN || st == ST_RUN)
                    return HND_INIT;
                return HND_FAULT;
            end
            EV_HOLD:       return (st == ST_READY) ? HND_READY : HND_FAULT;
            EV_READY:      return (st == ST_READY) ? HND_CALIB : HND_FAULT;
            EV_CALIB:      return (st == ST_CALIB) ? HND_CALIB : HND_FAULT;
            EV_CALIB_DONE: return (st == ST_CALIB) ? HND_ALIGN : HND_FAULT;
            EV_ALIGN:      return (st == ST_ALIGN) ? HND_ALIGN : HND_FAULT;
            EV_ALIGN_DONE: return (st == ST_ALIGN) ? HND_RUN : HND_FAULT;
            EV_RUN:        return (st == ST_RUN) ? HND_RUN : HND_FAULT;
            EV_FLASH_ON:   return (st == ST_READY) ? HND_RUN : HND_FAULT;
            default:       return HND_FAULT;
        endcase
    endfunction

    // Advance the sequencer copy by one tick and return what the block should emit.
    function automatic tick_result_t advance_sequencer(
        logic evv, logic [3:0] ev_in, logic [VBUS_W-1:0] vbus,
        logic [ADC_W-1:0] a, logic [ADC_W-1:0] b, logic [ADC_W-1:0] c,
        logic [ENC_W-1:0] enc);
        tick_result_t     r;
        logic [3:0]       ev;
        logic [ADC_W-1:0] smp [NUM_ADC];
        r = '0;
        smp[0] = a;
        smp[1] = b;
        smp[2] = c;
        ev = evv ? ev_in : seq_event;
        case (pick_handler(ev, seq_state))
            HND_RESET:
            begin
                seq_state = ST_RESET;
                seq_event = EV_START;
                r.pwm_off = 1'b1;
            end
            HND_INIT:
            begin
                seq_state = ST_INIT;
                r.pwm_off = 1'b1;
                r.drv     = 1'b1;
                seq_event = (vbus > win_low && vbus < win_high) ? EV_BUS_OK : EV_BUS_WAIT;
            end
            HND_READY:
            begin
                seq_state = ST_READY;
                seq_event = EV_READY;
            end
            HND_CALIB:
            begin
                seq_state = ST_CALIB;
                seq_event = EV_CALIB;
                if (calib_n < CALIB_SAMPLES) begin
                    for (int i = 0; i < NUM_ADC; i++)
                        calib_acc[i] = calib_acc[i] + SUM_W'(smp[i]);
                    calib_n = calib_n + 1'b1;
                end
                else begin
                    for (int i = 0; i < NUM_ADC; i++) begin
                        offs_hold[i] = ADC_W'(calib_acc[i] / calib_n);
                        calib_acc[i] = '0;
                    end
                    calib_n   = '0;
                    r.ovalid  = 1'b1;
                    seq_event = EV_CALIB_DONE;
                end
            end
            HND_ALIGN:
            begin
                seq_state = ST_ALIGN;
                seq_event = EV_ALIGN;
                if (align_n < align_len) begin
                    r.axis  = (align_ph == PH_D_AXIS) ? AXIS_D : AXIS_Q;
                    align_n = align_n + 1'b1;
                end
                else if (align_ph == PH_Q_AXIS) begin
                    align_ph = PH_Q_DONE;
                end
                else if (align_ph == PH_Q_DONE) begin
                    r.obs     = 1'b1;
                    align_n   = '0;
                    align_ph  = PH_D_AXIS;
                    seq_event = EV_ALIGN_DONE;
                end
                else begin
                    align_ph = PH_Q_AXIS;
                    align_n  = '0;
                    enc_hold = enc;
                end
            end
            HND_RUN:
            begin
                seq_state = ST_RUN;
                seq_event = EV_RUN;
                r.run     = 1'b1;
            end
            default:
            begin
                seq_state = ST_FAULT;
                seq_event = EV_FAULT;
                r.pwm_off = 1'b1;
            end
        endcase
        r.state   = seq_state;
        r.nxt     = seq_event;
        r.off_a   = offs_hold[0];
        r.off_b   = offs_hold[1];
        r.off_c   = offs_hold[2];
        r.enc_off = enc_hold;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        tick_result_t want;
        if (!rst_n) begin
            seq_state = ST_RESET;
            seq_event = EV_RESET;
            calib_n   = '0;
            align_n   = '0;
            align_ph  = PH_D_AXIS;
            enc_hold  = '0;
            for (int i = 0; i < NUM_ADC; i++) begin
                calib_acc[i] = '0;
                offs_hold[i] = '0;
            end
            win_low   = BUS_LOW_RST;
            win_high  = BUS_HIGH_RST;
            align_len = ALIGN_TICKS_RST;
            owed_q.delete();
            results_owed <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BUS_LOW:     win_low   = cfg_wdata;
                    CFG_BUS_HIGH:    win_high  = cfg_wdata;
                    CFG_ALIGN_TICKS: align_len = cfg_wdata;
                    default:         ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (owed_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end
                else begin
                    want = owed_q.pop_front();
                    check_field("state_code", state_code, want.state);
                    check_field("next_event", next_event, want.nxt);
                    check_field("pwm_disable", pwm_disable, want.pwm_off);
                    check_field("align_axis", align_axis, want.axis);
                    check_field("run_active", run_active, want.run);
                    check_field("driver_init", driver_init, want.drv);
                    check_field("offset_valid", offset_valid, want.ovalid);
                    check_field("offset_a", offset_a, want.off_a);
                    check_field("offset_b", offset_b, want.off_b);
                    check_field("offset_c", offset_c, want.off_c);
                    check_field("rotor_offset", rotor_offset, want.enc_off);
                    check_field("observer_init", observer_init, want.obs);
                end
            end
            if (in_valid && in_ready)
                owed_q.push_back(advance_sequencer(ext_event_valid, ext_event, bus_voltage,
                                                   adc_a, adc_b, adc_c, encoder_position));
            results_owed <= owed_q.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
// Top of the startup sequencer testbench: clock, reset, tick stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module testbench;
    import mss_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int TICK_BUDGET  = 1600;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int TAIL_CYCLES  = 4;
    // event code outside the transition table
    localparam logic [3:0] EV_UNKNOWN = 4'hF;

    typedef enum logic [1:0] {
        SINK_OPEN   = 2'd0,
        SINK_RANDOM = 2'd1,
        SINK_BLOCKS = 2'd2
    } sink_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 ext_event_valid = 1'b0;
    logic [3:0]           ext_event = '0;
    logic [VBUS_W-1:0]    bus_voltage = '0;
    logic [ADC_W-1:0]     adc_a = '0;
    logic [ADC_W-1:0]     adc_b = '0;
    logic [ADC_W-1:0]     adc_c = '0;
    logic [ENC_W-1:0]     encoder_position = '0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [2:0]           state_code;
    logic [3:0]           next_event;
    logic                 pwm_disable;
    logic [1:0]           align_axis;
    logic                 run_active;
    logic                 driver_init;
    logic                 offset_valid;
    logic [ADC_W-1:0]     offset_a;
    logic [ADC_W-1:0]     offset_b;
    logic [ADC_W-1:0]     offset_c;
    logic [ENC_W-1:0]     rotor_offset;
    logic                 observer_init;

    int                   mismatch_count;
    int                   results_owed;

    // sender pacing and the window the registers currently hold
    int unsigned          ticks_sent = 0;
    int unsigned          burst_left = 0;
    bit                   gaps_on = 1'b1;
    int unsigned          win_lo = BUS_LOW_RST;
    int unsigned          win_hi = BUS_HIGH_RST;

    // result-side stall pattern
    sink_mode_t           sink_mode = SINK_OPEN;
    int unsigned          sink_left = 0;
    int unsigned          sink_hold = 0;

    motor_startup_sequencer u_dut (.*);

    startup_seq_checker u_checker (.*);

    always #CLK_HALF clk = ~clk;

    // Stall the result side: stretches of always-ready, random stalls one time in four,
    // and blocks of stalled cycles in a row.
    always @(posedge clk) begin
        if (sink_left == 0) begin
            sink_mode = sink_mode_t'($urandom_range(0, 2));
            sink_left = $urandom_range(20, 200);
        end
        else begin
            sink_left--;
        end
        case (sink_mode)
            SINK_OPEN:   out_ready <= 1'b1;
            SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (sink_hold != 0) begin
                    sink_hold--;
                    out_ready <= 1'b0;
                end
                else begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        sink_hold = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Present one tick request and hold it until the block takes it.
    // When gaps are on, drop valid for a random gap between bursts.
    task automatic send_tick(input logic evv, input logic [3:0] ev, input logic [VBUS_W-1:0] vbus,
                             input logic [ADC_W-1:0] a, input logic [ADC_W-1:0] b,
                             input logic [ADC_W-1:0] c, input logic [ENC_W-1:0] enc);
        int unsigned gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 32);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else begin
                burst_left--;
            end
        end
        in_valid         <= 1'b1;
        ext_event_valid  <= evv;
        ext_event        <= ev;
        bus_voltage      <= vbus;
        adc_a            <= a;
        adc_b            <= b;
        adc_c            <= c;
        encoder_position <= enc;
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
    endtask

    // Tick with random phase currents and encoder reading.
    task automatic tick(input logic evv, input logic [3:0] ev, input logic [VBUS_W-1:0] vbus);
        send_tick(evv, ev, vbus, ADC_W'($urandom), ADC_W'($urandom), ADC_W'($urandom),
                  ENC_W'($urandom));
    endtask

    // Drop valid and hold until every owed result has been taken. The owed count
    // is registered, so always advance at least once before looking at it.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
    endtask

    // Write all three registers on consecutive edges; block must be idle.
    task automatic set_registers(input int unsigned lo, input int unsigned hi,
                                 input int unsigned align_len);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BUS_LOW;
        cfg_wdata <= CFG_W'(lo);
        @(posedge clk);
        cfg_index <= CFG_BUS_HIGH;
        cfg_wdata <= CFG_W'(hi);
        @(posedge clk);
        cfg_index <= CFG_ALIGN_TICKS;
        cfg_wdata <= CFG_W'(align_len);
        @(posedge clk);
        cfg_we <= 1'b0;
        win_lo = lo;
        win_hi = hi;
    endtask

    // Bus voltage mostly inside the window, sometimes right on its edges or anywhere.
    function automatic logic [VBUS_W-1:0] pick_vbus();
        case ($urandom_range(0, 9))
            0:       return VBUS_W'(win_lo);
            1:       return VBUS_W'(win_hi);
            2, 3:    return VBUS_W'($urandom);
            default: return (win_hi > win_lo + 1) ? VBUS_W'($urandom_range(win_lo + 1, win_hi - 1))
                                                  : VBUS_W'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        int unsigned pick;

        // hold reset, then release it once for the whole run
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed walk with the reset register values ----
        // stored reset event, external code ignored while its flag is low
        tick(1'b0, EV_UNKNOWN, 16'd0);
        // init: below, on and above the window, then strictly inside it
        tick(1'b0, EV_FAULT, 16'd0);
        tick(1'b0, EV_FAULT, BUS_LOW_RST);
        tick(1'b0, EV_FAULT, BUS_HIGH_RST);
        tick(1'b0, EV_FAULT, 16'hFFFF);
        tick(1'b0, EV_FAULT, BUS_LOW_RST + 1'b1);
        tick(1'b0, EV_FAULT, 16'd0);
        // ready-state events and the flash shortcut into run
        tick(1'b1, EV_HOLD, 16'd0);
        tick(1'b1, EV_RESTART, 16'd0);
        tick(1'b1, EV_FLASH_ON, 16'd0);
        tick(1'b0, EV_FAULT, 16'd0);
        // restart out of run, then force a bus wait and a reset from init
        tick(1'b1, EV_RESTART, BUS_HIGH_RST - 1'b1);
        tick(1'b1, EV_BUS_WAIT, 16'd0);
        tick(1'b1, EV_RESET, 16'd0);
        tick(1'b1, EV_START, 16'd30000);
        // unknown code lands in fault, fault holds, clear recovers
        tick(1'b1, EV_UNKNOWN, 16'd0);
        tick(1'b1, EV_FAULT, 16'd0);
        tick(1'b1, EV_CLEAR, 16'd30000);
        tick(1'b1, EV_BUS_OK, 16'd0);
        // calibration with full-scale and zero samples
        send_tick(1'b1, EV_READY, 16'd0, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF);
        send_tick(1'b1, EV_CALIB, 16'hFFFF, 12'h000, 12'h000, 12'h000, 16'h0000);
        // leave calibration part way into alignment, then on to run
        tick(1'b1, EV_CALIB_DONE, 16'd0);
        tick(1'b1, EV_ALIGN, 16'd0);
        tick(1'b1, EV_ALIGN_DONE, 16'd0);
        tick(1'b1, EV_RUN, 16'd0);

        // ---- random phases, each under a fresh register setting ----
        while (ticks_sent < TICK_BUDGET) begin
            // pause until the block has drained before touching the registers
            wait_idle();
            case ($urandom_range(0, 11))
                0:       set_registers(BUS_LOW_RST, BUS_HIGH_RST, ALIGN_TICKS_RST);
                1:       set_registers(0, 16'hFFFF, 1);
                2:       set_registers(16'hFFFF, 0, $urandom_range(1, 20));
                3:       set_registers($urandom_range(0, 2000), $urandom_range(50000, 65535), 0);
                4:       set_registers($urandom_range(0, 2000), 16'hFFFF, 16'hFFFF);
                default:
                begin
                    lo = $urandom_range(0, 30000);
                    hi = $urandom_range(lo, 65535);
                    set_registers(lo, hi, $urandom_range(1, 24));
                end
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);

            if ($urandom_range(0, 9) < 7) begin
                // well-formed start-up: force fault, clear into init, optionally
                // bounce through reset, then let the stored events carry the
                // machine through ready, calib, align and run
                tick(1'b1, EV_FAULT, pick_vbus());
                tick(1'b1, EV_CLEAR, pick_vbus());
                if ($urandom_range(0, 1) != 0)
                    tick(1'b1, EV_RESET, pick_vbus());
                span = $urandom_range(150, 600);
                repeat (span) begin
                    pick = $urandom_range(0, 999);
                    if (pick < 4)
                        tick(1'b1, EV_RESTART, pick_vbus());
                    else if (pick < 6)
                        tick(1'b1, 4'($urandom_range(0, 15)), pick_vbus());
                    else
                        tick(1'b0, 4'($urandom), pick_vbus());
                end
            end
            else begin
                // noise: random flags, codes and fields
                span = $urandom_range(20, 80);
                repeat (span)
                    tick(1'($urandom), 4'($urandom), VBUS_W'($urandom));
            end
        end

        // drain, let the pipeline settle, then read the verdict off-edge
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Bound the run in case a handshake never completes.
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mss_pkg.sv
hw/rtl/mss_calib.sv
hw/rtl/motor_startup_sequencer.sv
tb/sv/startup_seq_checker.sv
tb/sv/testbench.sv
